// ===== design/iafi_pkg.sv =====
// ----------------------------------------------------------------------------
// iafi_pkg
// Shared types, constants and helper functions of the arm and fire interlock.
// ----------------------------------------------------------------------------
package iafi_pkg;

  // counter width of the tick counters
  localparam int CNT_W = 16;
  localparam int THR_W = 16;
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int ID_W  = 11;
  localparam int LEN_W = 4;
  localparam int PL_W  = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARM_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESEND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PARTNER_ID = 3'd4;

  // reset values of the configuration registers
  localparam logic [THR_W-1:0] RST_ARM_WINDOW = 16'd200;
  localparam logic [THR_W-1:0] RST_RESEND     = 16'd20;
  localparam logic [THR_W-1:0] RST_HB_TIMEOUT = 16'd40;
  localparam logic [THR_W-1:0] RST_BLINK_ON   = 16'd4;
  localparam logic [ID_W-1:0]  RST_PARTNER_ID = 11'h013;

  // confirmation frames: length and payload words, byte zero lowest
  localparam logic [LEN_W-1:0] LEN_DISARM  = 4'd6;
  localparam logic [LEN_W-1:0] LEN_ARM     = 4'd3;
  localparam logic [LEN_W-1:0] LEN_FIRE    = 4'd4;
  localparam logic [47:0]      WORD_DISARM = 48'h4D5241534944;
  localparam logic [23:0]      WORD_ARM    = 24'h4D5241;
  localparam logic [31:0]      WORD_FIRE   = 32'h45524946;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    TG_DISARMED = 2'd0,
    TG_EXPIRED  = 2'd1,
    TG_ARMED    = 2'd2,
    TG_FIRE     = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    CF_DEAD     = 2'd0,
    CF_DISARMED = 2'd1,
    CF_ARMED    = 2'd2,
    CF_FIRE     = 2'd3
  } conf_t;

  typedef enum logic [1:0] {
    CMD_DISARM = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_FIRE   = 2'd2
  } cmd_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_MSG  = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic             arm_lever;
    logic             fire_button;
    logic [ID_W-1:0]  msg_id;
    logic             msg_extended;
    logic [LEN_W-1:0] msg_length;
    logic [PL_W-1:0]  msg_payload;
  } in_item_t;

  typedef struct packed {
    logic       send_now;
    logic [1:0] send_command;
    logic       indicator;
    logic       status_led;
    logic [1:0] target_code;
    logic [1:0] confirmed_code;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0] arm_window_ticks;
    logic [THR_W-1:0] resend_ticks;
    logic [THR_W-1:0] heartbeat_timeout_ticks;
    logic [THR_W-1:0] blink_on_ticks;
    logic [ID_W-1:0]  partner_id;
  } cfg_t;

  // frame decoder result
  typedef struct packed {
    logic  hit;
    conf_t code;
  } dec_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // counter strictly above threshold
  function automatic logic cnt_gt(input logic [CNT_W-1:0] c, input logic [THR_W-1:0] th);
    cnt_gt = CMP_W'(c) > CMP_W'(th);
  endfunction

  // counter strictly below threshold
  function automatic logic cnt_lt(input logic [CNT_W-1:0] c, input logic [THR_W-1:0] th);
    cnt_lt = CMP_W'(c) < CMP_W'(th);
  endfunction

  // command that belongs to a target
  function automatic cmd_t command_of(input target_t t);
    case (t)
      TG_ARMED: command_of = CMD_ARM;
      TG_FIRE:  command_of = CMD_FIRE;
      default:  command_of = CMD_DISARM;
    endcase
  endfunction

endpackage

// ===== design/iafi_if.sv =====
// ----------------------------------------------------------------------------
// iafi channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface iafi_in_if;
  logic              valid;
  logic              ready;
  iafi_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface iafi_out_if;
  logic               valid;
  logic               ready;
  iafi_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/iafi_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// iafi_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module iafi_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [iafi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iafi_pkg::CFG_DAT_W-1:0]     cfg_data,
  output iafi_pkg::cfg_t                     cfg
);
  import iafi_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_window_ticks        <= RST_ARM_WINDOW;
      cfg.resend_ticks            <= RST_RESEND;
      cfg.heartbeat_timeout_ticks <= RST_HB_TIMEOUT;
      cfg.blink_on_ticks          <= RST_BLINK_ON;
      cfg.partner_id              <= RST_PARTNER_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARM_WINDOW: cfg.arm_window_ticks        <= cfg_data[THR_W-1:0];
        REG_RESEND:     cfg.resend_ticks            <= cfg_data[THR_W-1:0];
        REG_HB_TIMEOUT: cfg.heartbeat_timeout_ticks <= cfg_data[THR_W-1:0];
        REG_BLINK_ON:   cfg.blink_on_ticks          <= cfg_data[THR_W-1:0];
        REG_PARTNER_ID: cfg.partner_id              <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/iafi_frame_decode.sv =====
// ----------------------------------------------------------------------------
// iafi_frame_decode
// Matches a received frame against the DISARM, ARM and FIRE confirmations.
// ----------------------------------------------------------------------------
module iafi_frame_decode (
  input  iafi_pkg::in_item_t           msg,
  input  logic [iafi_pkg::ID_W-1:0]    partner_id,
  output iafi_pkg::dec_t               dec
);
  import iafi_pkg::*;

  logic from_partner;

  // standard frame from the partner
  assign from_partner = (msg.msg_id == partner_id) && !msg.msg_extended;

  // first matching word wins
  always_comb begin
    dec.hit  = 1'b0;
    dec.code = CF_DEAD;
    if (from_partner && msg.msg_length == LEN_DISARM &&
        msg.msg_payload[47:0] == WORD_DISARM) begin
      dec.hit  = 1'b1;
      dec.code = CF_DISARMED;
    end else if (from_partner && msg.msg_length == LEN_ARM &&
                 msg.msg_payload[23:0] == WORD_ARM) begin
      dec.hit  = 1'b1;
      dec.code = CF_ARMED;
    end else if (from_partner && msg.msg_length == LEN_FIRE &&
                 msg.msg_payload[31:0] == WORD_FIRE) begin
      dec.hit  = 1'b1;
      dec.code = CF_FIRE;
    end
  end

endmodule

// ===== design/iafi_step.sv =====
// ----------------------------------------------------------------------------
// iafi_step
// Interlock state and the per-item update for ticks and messages.
// ----------------------------------------------------------------------------
module iafi_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  iafi_pkg::in_item_t  item,
  input  iafi_pkg::cfg_t      cfg,
  input  iafi_pkg::dec_t      dec,
  output iafi_pkg::out_item_t res
);
  import iafi_pkg::*;

  target_t          target, target_next, prev_target;
  conf_t            confirmed, confirmed_next;
  logic [CNT_W-1:0] arm_ticks, arm_ticks_next;
  logic [CNT_W-1:0] resend_count, resend_count_next;
  logic [CNT_W-1:0] hb_count, hb_count_next;
  logic             indicator_level, indicator_level_next;
  logic             led_level, led_level_next;
  logic             send;
  logic [CNT_W-1:0] arm_base;

  // next state of one item
  always_comb begin
    target_next          = target;
    confirmed_next       = confirmed;
    arm_ticks_next       = arm_ticks;
    resend_count_next    = resend_count;
    hb_count_next        = hb_count;
    indicator_level_next = indicator_level;
    led_level_next       = led_level;
    arm_base             = arm_ticks;
    send                 = 1'b0;
    if (item.kind == KIND_TICK) begin
      // arming from a confirmed disarmed partner
      if (confirmed == CF_DISARMED && target != TG_ARMED && target != TG_EXPIRED &&
          item.arm_lever) begin
        target_next = TG_ARMED;
        arm_base    = '0;
      end
      if (!item.arm_lever) target_next = TG_DISARMED;
      if (target_next == TG_ARMED && cnt_gt(arm_base, cfg.arm_window_ticks))
        target_next = TG_EXPIRED;
      if (confirmed == CF_ARMED && target_next == TG_ARMED && item.fire_button)
        target_next = TG_FIRE;
      if (confirmed == CF_DISARMED && target_next == TG_FIRE)
        target_next = TG_EXPIRED;
      // heartbeat timeout
      if (cnt_gt(hb_count, cfg.heartbeat_timeout_ticks)) begin
        target_next    = TG_DISARMED;
        confirmed_next = CF_DEAD;
      end
      // send on change or when resend is due
      send = (target_next != prev_target) || cnt_gt(resend_count, cfg.resend_ticks);
      arm_ticks_next    = sat_inc(arm_base);
      resend_count_next = send ? CNT_W'(1) : sat_inc(resend_count);
      hb_count_next     = sat_inc(hb_count);
      led_level_next    = !led_level;
      // indicator follows the partner state
      case (confirmed_next)
        CF_DEAD:     indicator_level_next = 1'b0;
        CF_DISARMED: indicator_level_next = cnt_lt(hb_count_next, cfg.blink_on_ticks);
        CF_ARMED:    indicator_level_next = 1'b1;
        default: begin
          if (!hb_count_next[0]) indicator_level_next = !indicator_level;
        end
      endcase
    end else begin
      hb_count_next = '0;
      if (dec.hit) confirmed_next = dec.code;
    end
  end

  // result of the item
  always_comb begin
    res.send_now       = send;
    res.send_command   = command_of(target_next);
    res.indicator      = indicator_level_next;
    res.status_led     = led_level_next;
    res.target_code    = target_next;
    res.confirmed_code = confirmed_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target          <= TG_DISARMED;
      confirmed       <= CF_DEAD;
      prev_target     <= TG_DISARMED;
      arm_ticks       <= '0;
      resend_count    <= '0;
      hb_count        <= '0;
      indicator_level <= 1'b0;
      led_level       <= 1'b0;
    end else if (en) begin
      target          <= target_next;
      confirmed       <= confirmed_next;
      if (item.kind == KIND_TICK) prev_target <= target_next;
      arm_ticks       <= arm_ticks_next;
      resend_count    <= resend_count_next;
      hb_count        <= hb_count_next;
      indicator_level <= indicator_level_next;
      led_level       <= led_level_next;
    end
  end

endmodule

// ===== design/igniter_arm_fire_interlock.sv =====
// ----------------------------------------------------------------------------
// igniter_arm_fire_interlock
// Arm and fire interlock with partner heartbeat supervision.
// An item goes to the input register, its result to the result register.
// Throughput: one item per cycle unless stalled by result.ready; the state update
// between the two registers is a single pass of compares and counter increments.
// Reset (rst, synchronous): empty pipeline, target disarmed, partner dead, all
// counters zero, configuration at its reset values.
// ----------------------------------------------------------------------------
module igniter_arm_fire_interlock (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [iafi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iafi_pkg::CFG_DAT_W-1:0] cfg_data,
  iafi_in_if.sink                        item,
  iafi_out_if.source                     result
);
  import iafi_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      adv;
  dec_t      dec;
  out_item_t step_res;
  out_item_t res_data;
  logic      res_valid;

  iafi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iafi_frame_decode u_dec (
    .msg        (s1_item),
    .partner_id (cfg.partner_id),
    .dec        (dec)
  );

  iafi_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .item (s1_item),
    .cfg  (cfg),
    .dec  (dec),
    .res  (step_res)
  );

  // advance when the result register is free or being drained
  assign adv        = s1_valid && (!res_valid || result.ready);
  assign item.ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) s1_item <= item.payload;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_data <= step_res;
  end

  assign result.valid   = res_valid;
  assign result.payload = res_data;

endmodule
